// ===== design/rfo_pkg.sv =====
// ----------------------------------------------------------------------------
// rfo_pkg
// Shared types and constants for the ring FIFO with overwrite.
// ----------------------------------------------------------------------------
`default_nettype none

package rfo_pkg;

    localparam int DEPTH_DEFAULT         = 16;
    localparam int ELEMENT_WIDTH_DEFAULT = 32;

    // Fixed field widths
    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Capacity after reset
    localparam int CAP_RESET = 16;

    // Packed beat widths, padded to whole bytes
    localparam int IN_W  = 40;
    localparam int OUT_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 3'd0,
        CMD_OVERWRITE = 3'd1,
        CMD_READ      = 3'd2,
        CMD_PEEK      = 3'd3,
        CMD_CLEAR     = 3'd4,
        CMD_STATUS    = 3'd5
    } cmd_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // input beat taken this cycle
        logic execute;   // apply the captured command
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being drained
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/rfo_ctrl.sv =====
// ----------------------------------------------------------------------------
// rfo_ctrl
// Sequencer: takes one command beat, executes it, then reopens the input.
// ----------------------------------------------------------------------------
`default_nettype none

module rfo_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire rfo_pkg::dp_status_t status,
    output rfo_pkg::ctl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready    = (state_reg == ST_IDLE) && status.out_free;
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.execute = (state_reg == ST_EXEC);

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = cmd.capture ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== design/rfo_datapath.sv =====
// ----------------------------------------------------------------------------
// rfo_datapath
// Slot memory, pointers, full flag, capacity register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfo_datapath
#(
    parameter int DEPTH         = rfo_pkg::DEPTH_DEFAULT,
    parameter int ELEMENT_WIDTH = rfo_pkg::ELEMENT_WIDTH_DEFAULT
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    input  wire logic [rfo_pkg::CAP_W-1:0]    cfg_data,
    input  wire logic [rfo_pkg::IN_W-1:0]     s_tdata,
    input  wire rfo_pkg::ctl_cmd_t            cmd,
    output rfo_pkg::dp_status_t               status,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [rfo_pkg::OUT_W-1:0]         m_tdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CW    = (PTR_W + 1 > rfo_pkg::CAP_W) ? PTR_W + 1 : rfo_pkg::CAP_W;
    localparam logic [rfo_pkg::CAP_W-1:0] CAP_RST =
        (DEPTH < rfo_pkg::CAP_RESET) ? rfo_pkg::CAP_W'(DEPTH)
                                     : rfo_pkg::CAP_W'(rfo_pkg::CAP_RESET);

    logic [ELEMENT_WIDTH-1:0]        mem [DEPTH];
    logic [ELEMENT_WIDTH-1:0]        mem_q_reg;

    logic [PTR_W-1:0]                wp_reg, wp_next;
    logic [PTR_W-1:0]                rp_reg, rp_next;
    logic                            full_reg, full_next;
    logic [rfo_pkg::CAP_W-1:0]       cap_reg, cap_next;

    rfo_pkg::cmd_t                   op_reg;
    logic [rfo_pkg::DATA_W-1:0]      wdata_reg;

    logic                            mvalid_reg, mvalid_next;
    logic [rfo_pkg::OUT_W-1:0]       mdata_reg;

    logic [PTR_W-1:0]                wp_inc, rp_inc, rp_adv;
    logic                            empty_now;
    logic                            mem_we;
    logic                            ok;
    logic [rfo_pkg::DATA_W-1:0]      rd;
    logic [CW-1:0]                   cnt;
    logic                            res_full, res_empty;

    // Pointer advance, wrapping at the capacity in use
    function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p,
                                            input logic [rfo_pkg::CAP_W-1:0] c);
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        return (n >= CW'(c)) ? '0 : PTR_W'(n);
    endfunction

    assign wp_inc    = nxt(wp_reg, cap_reg);
    assign rp_inc    = nxt(rp_reg, cap_reg);
    assign rp_adv    = full_reg ? rp_inc : rp_reg;
    assign empty_now = !full_reg && (wp_reg == rp_reg);

    // Capacity clamped to 1..DEPTH on write
    always_comb
    begin
        if (cfg_data == '0)
            cap_next = rfo_pkg::CAP_W'(1);
        else if (CW'(cfg_data) > CW'(DEPTH))
            cap_next = rfo_pkg::CAP_W'(DEPTH);
        else
            cap_next = cfg_data;
    end

    // Command decode and next pointer state
    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        full_next = full_reg;
        mem_we    = 1'b0;
        ok        = 1'b0;
        rd        = '0;
        case (op_reg)
            rfo_pkg::CMD_WRITE:
            begin
                if (!full_reg)
                begin
                    mem_we    = 1'b1;
                    wp_next   = wp_inc;
                    full_next = (wp_inc == rp_reg);
                    ok        = 1'b1;
                end
            end
            rfo_pkg::CMD_OVERWRITE:
            begin
                mem_we    = 1'b1;
                wp_next   = wp_inc;
                rp_next   = rp_adv;
                full_next = (wp_inc == rp_adv);
                ok        = 1'b1;
            end
            rfo_pkg::CMD_READ:
            begin
                if (!empty_now)
                begin
                    rd        = rfo_pkg::DATA_W'(mem_q_reg);
                    rp_next   = rp_inc;
                    full_next = 1'b0;
                    ok        = 1'b1;
                end
            end
            rfo_pkg::CMD_PEEK:
            begin
                if (!empty_now)
                begin
                    rd = rfo_pkg::DATA_W'(mem_q_reg);
                    ok = 1'b1;
                end
            end
            rfo_pkg::CMD_CLEAR:
            begin
                wp_next   = '0;
                rp_next   = '0;
                full_next = 1'b0;
                ok        = 1'b1;
            end
            rfo_pkg::CMD_STATUS:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Fill state after the command
    always_comb
    begin
        if (full_next)
            cnt = CW'(cap_reg);
        else if (wp_next >= rp_next)
            cnt = CW'(wp_next) - CW'(rp_next);
        else
            cnt = CW'(cap_reg) - CW'(rp_next) + CW'(wp_next);
    end

    assign res_full  = (cnt == CW'(cap_reg));
    assign res_empty = !full_next && (wp_next == rp_next);

    // Output register
    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (cmd.execute)
            mvalid_next = 1'b1;
        else if (m_tready)
            mvalid_next = 1'b0;
    end

    assign status.out_free = !mvalid_reg || m_tready;
    assign m_tvalid        = mvalid_reg;
    assign m_tdata         = mdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            full_reg   <= 1'b0;
            cap_reg    <= CAP_RST;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            mvalid_reg <= mvalid_next;
            if (cfg_valid)
            begin
                cap_reg  <= cap_next;
                wp_reg   <= '0;
                rp_reg   <= '0;
                full_reg <= 1'b0;
            end
            else if (cmd.execute)
            begin
                wp_reg   <= wp_next;
                rp_reg   <= rp_next;
                full_reg <= full_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= rfo_pkg::cmd_t'(s_tdata[rfo_pkg::CMD_W-1:0]);
            wdata_reg <= s_tdata[rfo_pkg::CMD_W +: rfo_pkg::DATA_W];
        end
        if (cmd.execute)
            mdata_reg <= {res_empty, res_full, cnt[rfo_pkg::CAP_W-1:0], rd, ok};
    end

    // Slot memory: tail read on capture, head write on execute
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            mem_q_reg <= mem[rp_reg];
        if (cmd.execute && mem_we)
            mem[wp_reg] <= ELEMENT_WIDTH'(wdata_reg);
    end

endmodule

`default_nettype wire

// ===== design/ring_fifo_with_overwrite.sv =====
// ----------------------------------------------------------------------------
// ring_fifo_with_overwrite
// Circular FIFO with write-if-room, write-overwrite, read, peek, clear and
// status commands.
//
// Each input beat carries one command and yields exactly one result beat with
// ok, read_data, element_count, is_full and is_empty as they stand after the
// command. For each beat, the slot at the tail pointer is first read out of the
// synchronous slot memory; then the command is applied, the head slot is
// written and the result register is loaded. The next beat is taken once that
// beat has executed and the result register is free or is being drained, so
// a new beat is not taken while one is in flight. Writing the capacity
// register (values clamp to 1..DEPTH) also empties the FIFO; write it only
// while no beat is in flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_with_overwrite
#(
    parameter int DEPTH         = rfo_pkg::DEPTH_DEFAULT,
    parameter int ELEMENT_WIDTH = rfo_pkg::ELEMENT_WIDTH_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    // Capacity register write
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [rfo_pkg::CAP_W-1:0]  cfg_data,

    // Command beats
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [rfo_pkg::IN_W-1:0]   s_tdata,  // command[2:0], write_data[34:3], pad

    // Result beats
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [rfo_pkg::OUT_W-1:0]       m_tdata   // ok[0], read_data[32:1],
                                                      // element_count[37:33],
                                                      // is_full[38], is_empty[39]
);

    rfo_pkg::ctl_cmd_t   cmd;
    rfo_pkg::dp_status_t status;

    // Register writes must land only while idle; user's duty, not enforced: the block always takes them
    assign cfg_ready = 1'b1;

    rfo_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rfo_datapath
    #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // One command in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a command is executing");

    // Every accepted beat has its result presented once the execute state has loaded the result register
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("result beat missing after accepted command");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39] == (m_tdata[37:33] == 5'd0)))
        else $error("is_empty disagrees with element_count");

    // Never both full and empty (capacity is at least one)
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[38] && m_tdata[39]))
        else $error("is_full and is_empty both set");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ring_fifo_with_overwrite.
//
// Command beats come from a backlog queue that a clocked driver empties. A
// shadow copy of the ring (slots, pointers, full flag, capacity) works out
// the reply to every accepted command, and a monitor checks each result beat
// against the oldest pending reply, field by field. A short directed run
// covers the corner cases. Random phases then step through several capacity
// settings, out-of-range ones included, with idle patterns on both sides.
// ----------------------------------------------------------------------------

module tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RING_SLOTS   = rfo_pkg::DEPTH_DEFAULT;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 115;
    localparam int TAIL_CYCLES  = 20;

    // Codes outside the command set; the block answers them with ok low
    localparam logic [rfo_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [rfo_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [rfo_pkg::CMD_W-1:0]  cmd;
        logic [rfo_pkg::DATA_W-1:0] data;
    } cmd_item_t;

    typedef struct {
        logic                       ok;
        logic [rfo_pkg::DATA_W-1:0] rdata;
        logic [rfo_pkg::CAP_W-1:0]  count;
        logic                       full;
        logic                       empty;
    } fifo_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [rfo_pkg::CAP_W-1:0]    cfg_data = '0;

    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [rfo_pkg::IN_W-1:0]     s_tdata = '0;   // command[2:0], write_data[34:3], pad

    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [rfo_pkg::OUT_W-1:0]    m_tdata;        // ok[0], read_data[32:1],
                                                  // element_count[37:33],
                                                  // is_full[38], is_empty[39]

    ring_fifo_with_overwrite u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Backlog of commands still to send, and replies owed by the block
    cmd_item_t   cmd_backlog[$];
    fifo_reply_t reply_due[$];

    // Handshake flags, set at the rising edge and read at the falling edge
    logic in_taken  = 1'b0;
    logic cfg_taken = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic fill_bias = 1'b1;

    int error_count     = 0;
    int replies_checked = 0;
    int write_rejects   = 0;
    int overwrite_drops = 0;
    int empty_misses    = 0;
    int cap_writes      = 0;
    int cycle_count     = 0;

    // Shadow state of the ring
    logic [rfo_pkg::DATA_W-1:0] shadow_slots [RING_SLOTS];
    int   shadow_wr   = 0;
    int   shadow_rd   = 0;
    logic shadow_full = 1'b0;
    int   shadow_cap  = rfo_pkg::CAP_RESET;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int eff_capacity();
        if (shadow_cap == 0)
            return 1;
        if (shadow_cap > RING_SLOTS)
            return RING_SLOTS;
        return shadow_cap;
    endfunction

    function automatic int ring_next(input int p);
        return (p + 1 >= eff_capacity()) ? 0 : p + 1;
    endfunction

    function automatic logic ring_empty();
        return !shadow_full && (shadow_wr == shadow_rd);
    endfunction

    function automatic void ring_push(input logic [rfo_pkg::DATA_W-1:0] v);
        shadow_slots[shadow_wr] = v;
        shadow_wr = ring_next(shadow_wr);
        shadow_full = (shadow_wr == shadow_rd);
    endfunction

    // Applies one command to the shadow ring and returns the reply it owes
    function automatic fifo_reply_t apply_command(input logic [rfo_pkg::CMD_W-1:0] cmd,
                                                  input logic [rfo_pkg::DATA_W-1:0] wdata);
        fifo_reply_t r;
        int cap;
        int cnt;
        r = '{ok: 1'b0, rdata: '0, count: '0, full: 1'b0, empty: 1'b0};
        case (cmd)
            rfo_pkg::CMD_WRITE:
                if (!shadow_full)
                begin
                    ring_push(wdata);
                    r.ok = 1'b1;
                end
                else
                    write_rejects++;
            rfo_pkg::CMD_OVERWRITE:
            begin
                if (shadow_full)
                begin
                    // oldest element goes to make room
                    shadow_rd = ring_next(shadow_rd);
                    overwrite_drops++;
                end
                ring_push(wdata);
                r.ok = 1'b1;
            end
            rfo_pkg::CMD_READ:
                if (!ring_empty())
                begin
                    r.rdata = shadow_slots[shadow_rd];
                    shadow_rd = ring_next(shadow_rd);
                    shadow_full = 1'b0;
                    r.ok = 1'b1;
                end
                else
                    empty_misses++;
            rfo_pkg::CMD_PEEK:
                if (!ring_empty())
                begin
                    r.rdata = shadow_slots[shadow_rd];
                    r.ok = 1'b1;
                end
                else
                    empty_misses++;
            rfo_pkg::CMD_CLEAR:
            begin
                shadow_wr = 0;
                shadow_rd = 0;
                shadow_full = 1'b0;
                r.ok = 1'b1;
            end
            rfo_pkg::CMD_STATUS:
                r.ok = 1'b1;
            default:
                ;
        endcase
        cap = eff_capacity();
        if (shadow_full)
            cnt = cap;
        else if (shadow_wr >= shadow_rd)
            cnt = shadow_wr - shadow_rd;
        else
            cnt = cap - shadow_rd + shadow_wr;
        r.count = cnt[rfo_pkg::CAP_W-1:0];
        r.full  = (cnt == cap);
        r.empty = ring_empty();
        return r;
    endfunction

    function automatic void compare_field(input string label,
                                          input logic [rfo_pkg::DATA_W-1:0] want,
                                          input logic [rfo_pkg::DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            error_count++;
        end
    endfunction

    // Monitor: capacity writes, accepted commands and result beats
    always @(posedge clk)
    begin
        fifo_reply_t want;
        fifo_reply_t got;
        if (rst_n)
        begin
            cfg_taken = cfg_valid && cfg_ready;
            in_taken  = s_tvalid && s_tready;
            if (cfg_taken)
            begin
                // capacity write also empties the ring
                shadow_cap  = int'(cfg_data);
                shadow_wr   = 0;
                shadow_rd   = 0;
                shadow_full = 1'b0;
                cap_writes++;
            end
            if (in_taken)
                reply_due.push_back(apply_command(s_tdata[rfo_pkg::CMD_W-1:0],
                                                  s_tdata[rfo_pkg::CMD_W +: rfo_pkg::DATA_W]));
            if (m_tvalid && m_tready)
            begin
                got.ok    = m_tdata[0];
                got.rdata = m_tdata[32:1];
                got.count = m_tdata[37:33];
                got.full  = m_tdata[38];
                got.empty = m_tdata[39];
                if (reply_due.size() == 0)
                begin
                    $display("%0t: result beat with none expected, actual %h", $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = reply_due.pop_front();
                    compare_field("ok", 32'(want.ok), 32'(got.ok));
                    compare_field("read_data", want.rdata, got.rdata);
                    compare_field("element_count", 32'(want.count), 32'(got.count));
                    compare_field("is_full", 32'(want.full), 32'(got.full));
                    compare_field("is_empty", 32'(want.empty), 32'(got.empty));
                    replies_checked++;
                end
            end
        end
    end

    // Command driver: hold the beat until taken, idle at random between beats
    always @(negedge clk)
    begin
        cmd_item_t it;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = cmd_backlog.pop_front();
                s_tdata  <= {{(rfo_pkg::IN_W - rfo_pkg::CMD_W - rfo_pkg::DATA_W){1'b0}},
                             it.data, it.cmd};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still owed", $time, reply_due.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [rfo_pkg::CMD_W-1:0] cmd,
                             input logic [rfo_pkg::DATA_W-1:0] data);
        cmd_item_t it;
        it.cmd  = cmd;
        it.data = data;
        cmd_backlog.push_back(it);
    endtask

    // Wait until every command is sent and every result has come back;
    // checked at the rising edge, where the driver's outputs are settled
    task automatic wait_drained();
        do
            @(posedge clk);
        while (cmd_backlog.size() != 0 || s_tvalid || reply_due.size() != 0);
    endtask

    task automatic write_capacity(input logic [rfo_pkg::CAP_W-1:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // Random commands, biased in runs towards filling or towards draining
    task automatic queue_random(input int n);
        int pick;
        logic [rfo_pkg::CMD_W-1:0] cmd;
        logic [rfo_pkg::DATA_W-1:0] data;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(15) == 0)
                fill_bias = !fill_bias;
            pick = $urandom_range(99);
            if (fill_bias)
                cmd = (pick < 40) ? rfo_pkg::CMD_WRITE :
                      (pick < 70) ? rfo_pkg::CMD_OVERWRITE :
                      (pick < 82) ? rfo_pkg::CMD_READ :
                      (pick < 90) ? rfo_pkg::CMD_PEEK :
                      (pick < 94) ? rfo_pkg::CMD_STATUS :
                      (pick < 96) ? rfo_pkg::CMD_CLEAR :
                      (pick < 98) ? CMD_SPARE_LO : CMD_SPARE_HI;
            else
                cmd = (pick < 15) ? rfo_pkg::CMD_WRITE :
                      (pick < 25) ? rfo_pkg::CMD_OVERWRITE :
                      (pick < 70) ? rfo_pkg::CMD_READ :
                      (pick < 85) ? rfo_pkg::CMD_PEEK :
                      (pick < 92) ? rfo_pkg::CMD_STATUS :
                      (pick < 95) ? rfo_pkg::CMD_CLEAR :
                      (pick < 97) ? CMD_SPARE_LO : CMD_SPARE_HI;
            case ($urandom_range(15))
                0:       data = '0;
                1:       data = '1;
                default: data = $urandom;
            endcase
            queue_cmd(cmd, data);
        end
    endtask

    // One capacity setting; the sender pauses halfway until all replies are in
    task automatic run_phase(input logic [rfo_pkg::CAP_W-1:0] cap, input int n);
        write_capacity(cap);
        queue_random(n / 2);
        wait_drained();
        queue_random(n - n / 2);
        wait_drained();
    endtask

    initial
    begin
        int phase_caps[PHASE_COUNT];
        phase_caps = '{16, 1, 0, 31, 17, 5, 3, 9, 2, 0};
        phase_caps[PHASE_COUNT-1] = $urandom_range(1, RING_SLOTS);
        for (int i = 0; i < RING_SLOTS; i++)
            shadow_slots[i] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: two slots, so full and empty come quickly
        write_capacity(5'd2);
        queue_cmd(rfo_pkg::CMD_PEEK, '0);                 // peek on empty
        queue_cmd(rfo_pkg::CMD_READ, '0);                 // read on empty
        queue_cmd(rfo_pkg::CMD_WRITE, '0);
        queue_cmd(rfo_pkg::CMD_WRITE, '1);                // now full
        queue_cmd(rfo_pkg::CMD_WRITE, 32'h1234_5678);     // rejected, no room
        queue_cmd(rfo_pkg::CMD_OVERWRITE, 32'hA5A5_A5A5); // oldest dropped
        queue_cmd(rfo_pkg::CMD_PEEK, '0);
        queue_cmd(rfo_pkg::CMD_READ, '0);
        queue_cmd(rfo_pkg::CMD_READ, '0);
        queue_cmd(rfo_pkg::CMD_READ, '0);                 // empty again
        queue_cmd(rfo_pkg::CMD_OVERWRITE, 32'h5A5A_5A5A); // overwrite with room: plain write
        queue_cmd(rfo_pkg::CMD_STATUS, '1);
        queue_cmd(rfo_pkg::CMD_CLEAR, '1);
        queue_cmd(rfo_pkg::CMD_STATUS, '0);
        queue_cmd(CMD_SPARE_LO, '1);
        queue_cmd(CMD_SPARE_HI, '1);
        queue_cmd(rfo_pkg::CMD_PEEK, '0);                 // nothing left after clear
        wait_drained();

        // Random phases: sender idles lightly and receiver heavily first, then the
        // other way round, then no idling at all
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p < 4)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 64;
            end
            else if (p < 7)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_phase(phase_caps[p][rfo_pkg::CAP_W-1:0], PHASE_ITEMS);
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (reply_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, reply_due.size());
            error_count += reply_due.size();
        end

        $display("tb: %0d results checked over %0d capacity settings (0 and >16 included)",
                 replies_checked, cap_writes);
        $display("tb: %0d full rejects, %0d overwrite drops, %0d empty reads/peeks",
                 write_rejects, overwrite_drops, empty_misses);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
